@@ sv/lswc_pkg.sv @@
// Shared types, constants and helpers for the line segment window clipper.
// No dependencies; every other file refers to this package by scoped names.

package lswc_pkg;

   // coordinate format: signed two's complement, Q8.8 by default
   localparam int COORD_BITS = 16;
   localparam int ADDR_BITS  = 4;
   localparam int DATA_BITS  = 32;
   localparam int MAX_PASSES = 8;
   localparam int PASS_BITS  = 4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0]   diff_type;
   typedef logic [COORD_BITS-1:0]        mag_type;
   typedef logic [3:0]                   code_type;

   // outcode bits
   localparam code_type CODE_LEFT  = 4'b1000;
   localparam code_type CODE_RIGHT = 4'b0100;
   localparam code_type CODE_BELOW = 4'b0010;
   localparam code_type CODE_ABOVE = 4'b0001;
   localparam code_type CODE_NONE  = 4'b0000;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_CORNER_A_X = 2'd0,
      REG_CORNER_A_Y = 2'd1,
      REG_CORNER_B_X = 2'd2,
      REG_CORNER_B_Y = 2'd3
   } reg_idx_type;

   // one stage of the divider chain
   typedef struct packed {
      logic    valid;
      mag_type rem;
      mag_type quo;
      mag_type dvs;
   } div_data_type;

   function automatic code_type outcode(coord_type x, coord_type y, coord_type xmin,
                                        coord_type xmax, coord_type ymin,
                                        coord_type ymax);
      code_type c;
      c = CODE_NONE;
      if (x < xmin) c = c | CODE_LEFT;
      if (x > xmax) c = c | CODE_RIGHT;
      if (y < ymin) c = c | CODE_BELOW;
      if (y > ymax) c = c | CODE_ABOVE;
      return c;
   endfunction

   function automatic diff_type widen(coord_type v);
      return diff_type'($signed({v[COORD_BITS-1], v}));
   endfunction

   // magnitude of a difference; all differences used stay below 2**COORD_BITS
   function automatic mag_type magnitude(diff_type v);
      diff_type n;
      n = v[COORD_BITS] ? -v : v;
      return n[COORD_BITS-1:0];
   endfunction

endpackage

@@ sv/lswc_if.sv @@
// Segment and result channel interfaces for the line segment window clipper.
// Depends on lswc_pkg.

interface lswc_req_if;
   logic                valid;
   logic                ready;
   lswc_pkg::coord_type start_x;
   lswc_pkg::coord_type start_y;
   lswc_pkg::coord_type end_x;
   lswc_pkg::coord_type end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lswc_rsp_if;
   logic                valid;
   logic                ready;
   lswc_pkg::coord_type clipped_start_x;
   lswc_pkg::coord_type clipped_start_y;
   lswc_pkg::coord_type clipped_end_x;
   lswc_pkg::coord_type clipped_end_y;

   modport source (output valid, clipped_start_x, clipped_start_y, clipped_end_x,
                   clipped_end_y, input ready);
   modport sink   (input valid, clipped_start_x, clipped_start_y, clipped_end_x,
                   clipped_end_y, output ready);
endinterface

@@ sv/lswc_div_cell.sv @@
// One restoring-division step: takes a partial remainder from its left neighbor,
// develops one quotient bit and hands the result on. Depends on lswc_pkg.

module lswc_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lswc_pkg::div_data_type stage_prev,
   output lswc_pkg::div_data_type stage_next
);

   lswc_pkg::div_data_type         stage_ff;
   lswc_pkg::div_data_type         stage_in;
   logic [lswc_pkg::COORD_BITS:0] trial;
   logic [lswc_pkg::COORD_BITS:0] diff;
   logic                          ge;

   // shift in next dividend bit, try subtracting the divisor
   always_comb begin
      trial = {stage_prev.rem, stage_prev.quo[lswc_pkg::COORD_BITS-1]};
      diff  = trial - {1'b0, stage_prev.dvs};
      ge    = !diff[lswc_pkg::COORD_BITS];
      stage_in.valid = stage_prev.valid;
      stage_in.rem   = ge ? diff[lswc_pkg::COORD_BITS-1:0]
                          : trial[lswc_pkg::COORD_BITS-1:0];
      stage_in.quo   = {stage_prev.quo[lswc_pkg::COORD_BITS-2:0], ge};
      stage_in.dvs   = stage_prev.dvs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.rem <= stage_in.rem;
      stage_ff.quo <= stage_in.quo;
      stage_ff.dvs <= stage_in.dvs;
   end

   assign stage_next = stage_ff;

endmodule

@@ sv/line_segment_window_clipper.sv @@
// Cohen-Sutherland segment clipper, signed fixed point, APB-configured window.
// Each segment takes k clip passes (k = 0..8) from segment transfer to result;
// each pass is outcode check, multiply, feed and a 16-cell divider chain.
// One segment at a time: a new segment is taken only once the last one is done,
// and a visible segment waits in ST_DONE while the result side stalls; dropped ones give no result.
// Reset (synchronous, active high): window corners (0,0) and (1536,1536), idle.
// Depends on lswc_pkg, lswc_if and lswc_div_cell.

module line_segment_window_clipper (
   input  logic                               clock,
   input  logic                               reset,
   lswc_req_if.sink                           req,
   lswc_rsp_if.source                         rsp,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lswc_pkg::ADDR_BITS-1:0]     csr_paddr,
   input  logic [lswc_pkg::DATA_BITS-1:0]     csr_pwdata,
   output logic [lswc_pkg::DATA_BITS-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int CW = lswc_pkg::COORD_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_FEED,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   lswc_pkg::coord_type ax_ff, ay_ff, bx_ff, by_ff;
   lswc_pkg::coord_type sx_ff, sy_ff, ex_ff, ey_ff;
   lswc_pkg::coord_type sx_in, sy_in, ex_in, ey_in;
   logic [lswc_pkg::PASS_BITS-1:0] pass_ff, pass_in;

   lswc_pkg::mag_type   mag_a_ff, mag_b_ff, mag_d_ff;
   lswc_pkg::mag_type   mag_a_in, mag_b_in, mag_d_in;
   logic                neg_ff, neg_in, vert_ff, vert_in, side_ff, side_in;
   lswc_pkg::coord_type bnd_ff, bnd_in, base_ff, base_in;
   logic [2*CW-1:0]     prod_ff, prod_in;

   logic                rsp_valid_ff, rsp_valid_in;
   lswc_pkg::coord_type osx_ff, osy_ff, oex_ff, oey_ff;
   lswc_pkg::coord_type osx_in, osy_in, oex_in, oey_in;

   lswc_pkg::coord_type xmin, xmax, ymin, ymax;
   lswc_pkg::code_type  cs, ce, cc, sel;
   lswc_pkg::coord_type bnd_c, along_s, along_e, other_s, other_e;
   lswc_pkg::diff_type  da, db, dd;
   lswc_pkg::mag_type   quo;
   logic [CW+1:0]       sum;
   lswc_pkg::coord_type new_other, pt_x, pt_y;
   logic                csr_write;

   lswc_pkg::div_data_type link [CW+1];

   // window bounds from the two corners
   always_comb begin
      xmin = (ax_ff < bx_ff) ? ax_ff : bx_ff;
      xmax = (ax_ff < bx_ff) ? bx_ff : ax_ff;
      ymin = (ay_ff < by_ff) ? ay_ff : by_ff;
      ymax = (ay_ff < by_ff) ? by_ff : ay_ff;
   end

   // configuration port
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (lswc_pkg::reg_idx_type'(csr_paddr[3:2]))
         lswc_pkg::REG_CORNER_A_X: csr_prdata = {{(lswc_pkg::DATA_BITS-CW){ax_ff[CW-1]}}, ax_ff};
         lswc_pkg::REG_CORNER_A_Y: csr_prdata = {{(lswc_pkg::DATA_BITS-CW){ay_ff[CW-1]}}, ay_ff};
         lswc_pkg::REG_CORNER_B_X: csr_prdata = {{(lswc_pkg::DATA_BITS-CW){bx_ff[CW-1]}}, bx_ff};
         lswc_pkg::REG_CORNER_B_Y: csr_prdata = {{(lswc_pkg::DATA_BITS-CW){by_ff[CW-1]}}, by_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   // divider chain
   always_comb begin
      link[0].valid = (state_ff == ST_FEED);
      link[0].rem   = prod_ff[2*CW-1:CW];
      link[0].quo   = prod_ff[CW-1:0];
      link[0].dvs   = mag_d_ff;
   end

   for (genvar i = 0; i < CW; i++) begin : g_cell
      lswc_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .stage_prev (link[i]),
         .stage_next (link[i+1])
      );
   end

   // outcodes and clip set-up
   always_comb begin
      cs  = lswc_pkg::outcode(sx_ff, sy_ff, xmin, xmax, ymin, ymax);
      ce  = lswc_pkg::outcode(ex_ff, ey_ff, xmin, xmax, ymin, ymax);
      cc  = cs | ce;
      priority if (cc[3]) sel = lswc_pkg::CODE_LEFT;
      else if (cc[2])     sel = lswc_pkg::CODE_RIGHT;
      else if (cc[1])     sel = lswc_pkg::CODE_BELOW;
      else                sel = lswc_pkg::CODE_ABOVE;
      vert_in = (sel == lswc_pkg::CODE_LEFT) || (sel == lswc_pkg::CODE_RIGHT);
      unique case (sel)
         lswc_pkg::CODE_LEFT:  bnd_c = xmin;
         lswc_pkg::CODE_RIGHT: bnd_c = xmax;
         lswc_pkg::CODE_BELOW: bnd_c = ymin;
         default:              bnd_c = ymax;
      endcase
      along_s = vert_in ? sx_ff : sy_ff;
      along_e = vert_in ? ex_ff : ey_ff;
      other_s = vert_in ? sy_ff : sx_ff;
      other_e = vert_in ? ey_ff : ex_ff;
      da = lswc_pkg::widen(bnd_c) - lswc_pkg::widen(along_s);
      db = lswc_pkg::widen(other_e) - lswc_pkg::widen(other_s);
      dd = lswc_pkg::widen(along_e) - lswc_pkg::widen(along_s);
   end

   // intersection from the chain output
   always_comb begin
      quo       = (mag_d_ff != '0) ? link[CW].quo : '0;
      sum       = {{2{base_ff[CW-1]}}, base_ff}
                + (neg_ff ? -{2'b00, quo} : {2'b00, quo});
      new_other = sum[CW-1:0];
      pt_x      = vert_ff ? bnd_ff : new_other;
      pt_y      = vert_ff ? new_other : bnd_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      pass_in      = pass_ff;
      mag_a_in     = mag_a_ff;
      mag_b_in     = mag_b_ff;
      mag_d_in     = mag_d_ff;
      neg_in       = neg_ff;
      side_in      = side_ff;
      bnd_in       = bnd_ff;
      base_in      = base_ff;
      prod_in      = prod_ff;
      osx_in       = osx_ff;
      osy_in       = osy_ff;
      oex_in       = oex_ff;
      oey_in       = oey_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               sx_in    = req.start_x;
               sy_in    = req.start_y;
               ex_in    = req.end_x;
               ey_in    = req.end_y;
               pass_in  = '0;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            priority if (cc == lswc_pkg::CODE_NONE) begin
               state_in = ST_DONE;
            end else if ((cs & ce) != lswc_pkg::CODE_NONE ||
                         pass_ff == lswc_pkg::PASS_BITS'(lswc_pkg::MAX_PASSES)) begin
               state_in = ST_IDLE;
            end else begin
               mag_a_in = lswc_pkg::magnitude(da);
               mag_b_in = lswc_pkg::magnitude(db);
               mag_d_in = lswc_pkg::magnitude(dd);
               neg_in   = da[CW] ^ db[CW] ^ dd[CW];
               side_in  = (cs & sel) != lswc_pkg::CODE_NONE;
               bnd_in   = bnd_c;
               base_in  = other_s;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mag_a_ff * mag_b_ff;
            state_in = ST_FEED;
         end
         ST_FEED: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (link[CW].valid) begin
               if (side_ff) begin
                  sx_in = pt_x;
                  sy_in = pt_y;
               end else begin
                  ex_in = pt_x;
                  ey_in = pt_y;
               end
               pass_in  = pass_ff + 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               osx_in       = sx_ff;
               osy_in       = sy_ff;
               oex_in       = ex_ff;
               oey_in       = ey_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= '0;
         ax_ff        <= lswc_pkg::coord_type'(0);
         ay_ff        <= lswc_pkg::coord_type'(0);
         bx_ff        <= lswc_pkg::coord_type'(1536);
         by_ff        <= lswc_pkg::coord_type'(1536);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
         if (csr_write) begin
            unique case (lswc_pkg::reg_idx_type'(csr_paddr[3:2]))
               lswc_pkg::REG_CORNER_A_X: ax_ff <= csr_pwdata[CW-1:0];
               lswc_pkg::REG_CORNER_A_Y: ay_ff <= csr_pwdata[CW-1:0];
               lswc_pkg::REG_CORNER_B_X: bx_ff <= csr_pwdata[CW-1:0];
               lswc_pkg::REG_CORNER_B_Y: by_ff <= csr_pwdata[CW-1:0];
               default: ;
            endcase
         end
      end
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      ex_ff    <= ex_in;
      ey_ff    <= ey_in;
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      mag_d_ff <= mag_d_in;
      neg_ff   <= neg_in;
      vert_ff  <= (state_ff == ST_EVAL) ? vert_in : vert_ff;
      side_ff  <= side_in;
      bnd_ff   <= bnd_in;
      base_ff  <= base_in;
      prod_ff  <= prod_in;
      osx_ff   <= osx_in;
      osy_ff   <= osy_in;
      oex_ff   <= oex_in;
      oey_ff   <= oey_in;
   end

   assign req.ready           = (state_ff == ST_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.clipped_start_x = osx_ff;
   assign rsp.clipped_start_y = osy_ff;
   assign rsp.clipped_end_x   = oex_ff;
   assign rsp.clipped_end_y   = oey_ff;

endmodule

@@ sv/lswc_checker.sv @@
// Port-level checks for the line segment window clipper, bound to the top level.
// Depends on lswc_pkg and line_segment_window_clipper.

module lswc_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input lswc_pkg::coord_type rsp_start_x,
   input lswc_pkg::coord_type rsp_end_x
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_start_x) && $stable(rsp_end_x))
      else $error("result payload changed while stalled");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // no result rises as a segment is accepted; at least ST_EVAL and ST_DONE lie between
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

endmodule

bind line_segment_window_clipper lswc_checker u_lswc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_start_x (rsp.clipped_start_x),
   .rsp_end_x   (rsp.clipped_end_x)
);
